FILE: hdl/tgm_pkg.sv
// Shared constants and types for the tremolo gain modulator.
`default_nettype none

package tgm_pkg;

  // Q1.15 unity and the operand width that holds it as a positive signed value
  localparam int Q_ONE = 32768;
  localparam int Q_OPW = 18;

  // Configuration register widths and reset values
  localparam int STEP_W      = 31;
  localparam int DEPTH_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 31'd447392;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd16384;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP = 1'b0,
    REG_DEPTH      = 1'b1
  } cfg_reg_t;

  // Control from the sequencer to the oscillator
  typedef struct packed {
    logic              advance;
    logic [STEP_W-1:0] step;
  } phase_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/tremolo_gain_modulator.sv
// Top level: tremolo gain modulator with sequencer, shared multiplier and output register.
`default_nettype none

// The result is offered once the sequencer has passed ST_LFO, ST_GAIN and ST_OUT.
// The single registered multiplier forms x*(1-|x|), depth*lfo and sample*gain in
// turn, one product per cycle outside ST_OUT, in which it holds its last product.
// The input is taken again once the sequencer is back in idle; a held output
// stalls the final step only while the output register is still occupied.
// Reset: phase cleared, phase_step and depth at their defaults, output empty.

module tremolo_gain_modulator #(
  parameter int SAMPLE_BITS = 24,
  parameter int PHASE_BITS  = 32
) (
  input  wire logic clk,
  input  wire logic rst,

  // Input stream
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // [SAMPLE_BITS-1:0] sample_in

  // Output stream
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  output      logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,  // [SAMPLE_BITS-1:0] sample_out

  // Configuration write channel
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [tgm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tgm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int TDATA_W = ((SAMPLE_BITS+7)/8)*8;
  localparam int QW      = tgm_pkg::Q_OPW;
  // Operand A carries the sample, or a Q1.15 value with headroom
  localparam int A_W     = (SAMPLE_BITS > QW) ? SAMPLE_BITS : QW;
  localparam int B_W     = QW;
  localparam int P_W     = A_W + B_W;

  typedef enum logic [1:0] {
    ST_IDLE,  // waiting; on a transaction, issue x*(1-|x|)
    ST_LFO,   // form s and lfo, issue depth*lfo
    ST_GAIN,  // form gain, issue sample*gain
    ST_OUT    // scale the product and load the output register
  } state_t;

  state_t state;

  // Configuration registers
  logic [tgm_pkg::STEP_W-1:0]  phase_step;
  logic [tgm_pkg::DEPTH_W-1:0] depth;

  logic                          in_fire;
  logic                          out_free;
  logic signed [SAMPLE_BITS-1:0] sample;

  tgm_pkg::phase_ctrl_t phase_ctrl;
  logic signed [15:0]   x;

  // Oscillator arithmetic
  logic signed [16:0]   x_ext;
  logic [16:0]          ax;
  logic [16:0]          one_minus_ax;
  logic signed [16:0]   s;
  logic signed [17:0]   lfo_diff;
  logic [16:0]          lfo;
  logic [16:0]          depth_sat;
  logic [P_W-1:0]       prod_shr15;
  logic [16:0]          gain;
  logic signed [SAMPLE_BITS-1:0] y;

  // Shared multiplier
  logic                  mul_en;
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic signed [P_W-1:0] prod;

  assign in_fire   = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // Configuration writes; the user keeps the block idle while they arrive, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= tgm_pkg::STEP_RESET;
      depth      <= tgm_pkg::DEPTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (tgm_pkg::cfg_reg_t'(cfg_index))
        tgm_pkg::REG_PHASE_STEP: phase_step <= cfg_data[tgm_pkg::STEP_W-1:0];
        tgm_pkg::REG_DEPTH:      depth      <= cfg_data[tgm_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // The phase is read for this sample in ST_IDLE, then advanced on the transaction
  assign phase_ctrl.advance = in_fire;
  assign phase_ctrl.step    = phase_step;

  tgm_phase #(
    .PHASE_BITS(PHASE_BITS)
  ) u_phase (
    .clk  (clk),
    .rst  (rst),
    .ctrl (phase_ctrl),
    .x    (x)
  );

  // |x| reaches 32768, so widen before negating
  assign x_ext        = 17'(x);
  assign ax           = x_ext[16] ? 17'(-x_ext) : 17'(x_ext);
  assign one_minus_ax = 17'(tgm_pkg::Q_ONE) - ax;

  // s = x*(1-|x|) >> 13, within -32768..32768
  assign s        = 17'(prod >>> 13);
  assign lfo_diff = 18'(tgm_pkg::Q_ONE) - 18'(s);
  // lfo_diff is never negative: halve by dropping the low bit
  assign lfo      = lfo_diff[17:1];

  // Saturate depth at full scale
  assign depth_sat = (depth > 16'(tgm_pkg::Q_ONE)) ? 17'(tgm_pkg::Q_ONE) : 17'(depth);

  assign prod_shr15 = P_W'(prod >>> 15);
  assign gain       = 17'(tgm_pkg::Q_ONE) - prod_shr15[16:0];
  assign y          = SAMPLE_BITS'(prod >>> 15);

  // Hold the final product while the sequencer is in ST_OUT
  assign mul_en = (state != ST_OUT);

  // Select multiplier operands for the step in progress
  always_comb begin
    case (state)
      ST_IDLE: begin
        mul_a = A_W'(x);
        mul_b = B_W'(one_minus_ax);
      end
      ST_LFO: begin
        mul_a = A_W'(depth_sat);
        mul_b = B_W'(lfo);
      end
      ST_GAIN: begin
        mul_a = A_W'(sample);
        mul_b = B_W'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tgm_mul #(
    .A_W(A_W),
    .B_W(B_W)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_LFO;
          end
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        ST_LFO: begin
          state <= ST_GAIN;
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        ST_GAIN: begin
          state <= ST_OUT;
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        ST_OUT: begin
          // Hold the final product until the output register frees up
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample <= s_tdata[SAMPLE_BITS-1:0];
    end
    if (state == ST_OUT && out_free) begin
      m_tdata <= TDATA_W'(unsigned'(y));
    end
  end

  // An accepted sample starts the oscillator step next
  a_seq_start: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_LFO)
    else $error("sequencer did not start after an input transaction");

  // A finished product lands in the output register when it is free
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) && out_free |=> m_tvalid && (state == ST_IDLE))
    else $error("result not loaded into the output register");

  // A held result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) && !out_free |=> (state == ST_OUT) && $stable(m_tdata))
    else $error("held result overwritten");

  // The oscillator stays within Q1.15 unity
  a_lfo_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LFO) |-> lfo <= 17'(tgm_pkg::Q_ONE))
    else $error("lfo out of range");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GAIN) |-> prod_shr15 <= P_W'(tgm_pkg::Q_ONE))
    else $error("depth*lfo out of range");

endmodule

`default_nettype wire

FILE: hdl/tgm_mul.sv
// Shared registered signed multiplier.
`default_nettype none

module tgm_mul #(
  parameter int A_W = 24,
  parameter int B_W = 18
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic signed [A_W-1:0]     a,
  input  wire logic signed [B_W-1:0]     b,
  output      logic signed [A_W+B_W-1:0] prod
);

  // Register the product when enabled and hold it otherwise;
  // consumers read it in the cycle after issue
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tgm_phase.sv
// LFO phase accumulator and the Q1.15 oscillator coordinate.
`default_nettype none

module tgm_phase #(
  parameter int PHASE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tgm_pkg::phase_ctrl_t ctrl,
  output      logic signed [15:0] x
);

  localparam int SUM_W = (PHASE_BITS > tgm_pkg::STEP_W) ? PHASE_BITS : tgm_pkg::STEP_W;

  logic [PHASE_BITS-1:0] phase;
  logic [SUM_W-1:0]      sum;

  assign sum = SUM_W'(phase) + SUM_W'(ctrl.step);

  // x = top16(phase) - 32768: flip the top bit
  assign x = {~phase[PHASE_BITS-1], phase[PHASE_BITS-2:PHASE_BITS-16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (ctrl.advance) begin
      phase <= sum[PHASE_BITS-1:0];
    end
  end

  // Hold the phase between accepted samples
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !ctrl.advance |=> $stable(phase))
    else $error("phase moved without an accepted sample");

  // Advance by exactly the step, wrapping
  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    ctrl.advance |=> phase == $past(sum[PHASE_BITS-1:0]))
    else $error("phase advanced by the wrong amount");

  a_phase_reset: assert property (@(posedge clk)
    rst |=> phase == '0)
    else $error("phase not cleared by reset");

endmodule

`default_nettype wire

FILE: tb/tremolo_gain_modulator_tb.sv
// Self-checking testbench for the tremolo gain modulator: stream stimulus, LFO gain predictor.
`timescale 1ns / 100ps

module tremolo_gain_modulator_tb;

  localparam int SAMPLE_W    = 24;
  localparam int DATA_W      = ((SAMPLE_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 2000;  // cycles with no transaction on any channel
  localparam int DRAIN_WAIT  = 12;    // extra wait after the last expected result has been taken

  // Directed rows either write a register or send one sample
  typedef enum bit {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    tgm_pkg::cfg_reg_t              reg_sel;
    logic [tgm_pkg::CFG_DATA_W-1:0] value;   // register data, or the sample in the low bits
    bit                             typed;   // compare against want instead of the predictor
    logic [SAMPLE_W-1:0]            want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [DATA_W-1:0]              s_tdata   = '0;  // [23:0] sample_in
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [DATA_W-1:0]              m_tdata;         // [23:0] sample_out
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tgm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tgm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor state: oscillator phase and the two registers as the block holds them
  logic [31:0]                  lfo_phase_model = '0;
  logic [tgm_pkg::STEP_W-1:0]   step_model      = tgm_pkg::STEP_RESET;
  logic [tgm_pkg::DEPTH_W-1:0]  depth_model     = tgm_pkg::DEPTH_RESET;

  logic [SAMPLE_W-1:0] expected_samples[$];
  int                  mismatches      = 0;
  int                  quiet_cycles    = 0;
  int                  src_idle_pct    = 29;
  int                  sink_idle_pct   = 87;

  // Directed part: extremes of the sample, both registers, depth above full,
  // upper data bits ignored by the depth register, zero and very large steps.
  // Typed results: at phase zero with reset settings the gain is exactly 3/4,
  // a zero sample gives zero, and zero depth passes the sample unchanged.
  dir_row_t dir_rows [0:31] = '{
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0800000, 1'b1, 24'hA00000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h07FFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0000000, 1'b1, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0000001, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0FFFFFF, 1'b0, 24'h000000},
    '{ROW_CONFIG, tgm_pkg::REG_PHASE_STEP, 31'h0000000, 1'b0, 24'h000000},
    '{ROW_CONFIG, tgm_pkg::REG_DEPTH,      31'h0000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h07FFFFF, 1'b1, 24'h7FFFFF},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0800000, 1'b1, 24'h800000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0555555, 1'b1, 24'h555555},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0AAAAAA, 1'b1, 24'hAAAAAA},
    '{ROW_CONFIG, tgm_pkg::REG_DEPTH,      31'h0008000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h07FFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0800000, 1'b0, 24'h000000},
    '{ROW_CONFIG, tgm_pkg::REG_DEPTH,      31'h000FFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h07FFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0800000, 1'b0, 24'h000000},
    '{ROW_CONFIG, tgm_pkg::REG_DEPTH,      31'h7FFF0000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0123456, 1'b1, 24'h123456},
    '{ROW_CONFIG, tgm_pkg::REG_PHASE_STEP, 31'h7FFFFFFF, 1'b0, 24'h000000},
    '{ROW_CONFIG, tgm_pkg::REG_DEPTH,      31'h0008000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h07FFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0800000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h07FFFFF, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0FFFFFF, 1'b0, 24'h000000},
    '{ROW_CONFIG, tgm_pkg::REG_PHASE_STEP, 31'h40000000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0800000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0800000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0800000, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0800000, 1'b0, 24'h000000},
    '{ROW_CONFIG, tgm_pkg::REG_PHASE_STEP, 31'h0000001, 1'b0, 24'h000000},
    '{ROW_SAMPLE, tgm_pkg::REG_DEPTH,      31'h0400000, 1'b0, 24'h000000}
  };

  tremolo_gain_modulator uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Gain for the current phase applied to one sample. Every shift is a floor,
  // which >>> on a signed longint gives directly.
  function automatic logic [SAMPLE_W-1:0] apply_tremolo(input logic [SAMPLE_W-1:0] smp);
    longint x, ax, s, lfo, d, gain, y;
    x    = longint'(lfo_phase_model[31:16]) - tgm_pkg::Q_ONE;
    ax   = (x < 0) ? -x : x;
    s    = (x * (tgm_pkg::Q_ONE - ax)) >>> 13;
    lfo  = (tgm_pkg::Q_ONE - s) >>> 1;
    // depth saturates at unity
    d    = (depth_model > tgm_pkg::Q_ONE) ? tgm_pkg::Q_ONE : longint'(depth_model);
    gain = tgm_pkg::Q_ONE - ((d * lfo) >>> 15);
    y    = (longint'($signed(smp)) * gain) >>> 15;
    return y[SAMPLE_W-1:0];
  endfunction

  // Write one register once the block has handed back every pending result.
  task automatic write_reg(input tgm_pkg::cfg_reg_t sel,
                           input logic [tgm_pkg::CFG_DATA_W-1:0] value);
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    // Leave cfg_valid high: the next write reuses it, a sample transaction drops it
    case (sel)
      tgm_pkg::REG_PHASE_STEP: step_model  = value[tgm_pkg::STEP_W-1:0];
      tgm_pkg::REG_DEPTH:      depth_model = value[tgm_pkg::DEPTH_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one sample after a random gap, then record what the block must return.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                             input logic [SAMPLE_W-1:0] want);
    logic [SAMPLE_W-1:0] predicted;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    predicted = apply_tremolo(smp);
    // Phase is read first, then advanced; the 32-bit sum wraps by itself
    lfo_phase_model = lfo_phase_model + {1'b0, step_model};
    expected_samples.push_back(typed ? want : predicted);
  endtask

  // Receiver: stall at random; one nonblocking update per edge
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare every output transaction with the oldest expectation
  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output transaction, sample_out %h", $time,
                   m_tdata[SAMPLE_W-1:0]);
      end else begin
        want = expected_samples.pop_front();
        if (m_tdata[SAMPLE_W-1:0] !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: sample_out expected %h, actual %h", $time, want,
                     m_tdata[SAMPLE_W-1:0]);
        end
      end
    end
  end

  // Watchdog: give up when no channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [tgm_pkg::CFG_DATA_W-1:0] step_val, depth_val;
    logic [SAMPLE_W-1:0]            smp;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CONFIG)
        write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
      else
        send_sample(dir_rows[i].value[SAMPLE_W-1:0], dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: three idling modes, five register settings each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin src_idle_pct = 29; sink_idle_pct = 87; end
        1:       begin src_idle_pct = 87; sink_idle_pct = 29; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      for (int setting = 0; setting < 5; setting++) begin
        case ($urandom_range(5))
          0:       step_val = '0;
          1:       step_val = 31'h7FFFFFFF;
          2:       step_val = 31'd1;
          3:       step_val = tgm_pkg::CFG_DATA_W'($urandom_range(100000, 2000000));
          4:       step_val = tgm_pkg::CFG_DATA_W'($urandom_range(1, 4096));
          default: step_val = tgm_pkg::CFG_DATA_W'($urandom);
        endcase
        case ($urandom_range(5))
          0:       depth_val = '0;
          1:       depth_val = 31'd32768;
          2:       depth_val = {(tgm_pkg::CFG_DATA_W-16)'($urandom >> 16), 16'hFFFF};
          3:       depth_val = tgm_pkg::CFG_DATA_W'($urandom_range(0, 32768));
          4:       depth_val = tgm_pkg::CFG_DATA_W'($urandom_range(32769, 65535));
          default: depth_val = tgm_pkg::CFG_DATA_W'($urandom);
        endcase
        if ($urandom_range(1)) begin
          write_reg(tgm_pkg::REG_PHASE_STEP, step_val);
          write_reg(tgm_pkg::REG_DEPTH, depth_val);
        end else begin
          write_reg(tgm_pkg::REG_DEPTH, depth_val);
          write_reg(tgm_pkg::REG_PHASE_STEP, step_val);
        end
        repeat (110) begin
          case ($urandom_range(15))
            0:       smp = 24'h7FFFFF;
            1:       smp = 24'h800000;
            2:       smp = $urandom_range(1) ? 24'h000000 : 24'hFFFFFF;
            default: smp = SAMPLE_W'($urandom);
          endcase
          send_sample(smp, 1'b0, '0);
        end
      end
    end

    // Drain: hold the inputs idle until every result is back, then allow the latency
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
